### rtl/core/add_months_end_of_month_date_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the add-months date core
// Shared immediate-style wrappers around concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ADD_MONTHS_END_OF_MONTH_DATE_CORE_MACROS_SVH
`define ADD_MONTHS_END_OF_MONTH_DATE_CORE_MACROS_SVH

// Whenever the condition holds, the consequence must hold in the same cycle.
`define AMED_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The expression must never be true.
`define AMED_ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);

`endif

### rtl/core/amed_pkg.sv
// ----------------------------------------------------------------------------
// Add-months date core package
// Shared types, calendar tables and constants of the date pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amed_pkg;

    // Days in one 400-year Gregorian cycle.
    localparam logic [17:0] ERA_DAYS = 18'd146097;

    // Exact reciprocal of 365 and of 1460 for 18-bit dividends.
    localparam logic [18:0] RECIP_365 = 19'd367720;

    localparam logic [31:0] POS_INF = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_INF = 32'h8000_0001;

    typedef struct packed {
        logic        inf;
        logic        inf_neg;
        logic        at_end;
        logic [4:0]  day;
        logic [32:0] midx;
    } split_t;

    typedef struct packed {
        logic               inf;
        logic               inf_neg;
        logic [8:0]         yoe;
        logic signed [20:0] era;
        logic [4:0]         day;
        logic [3:0]         mp;
    } shift_t;

    // First day of month mp in a year that starts in March.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Leap test for a year given modulo 400, in the range 0 to 400.
    function automatic logic is_leap400(input logic [8:0] y);
        return (y[1:0] == 2'd0) && !(y inside {9'd100, 9'd200, 9'd300});
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        if (m == 4'd2) begin
            r = leap ? 5'd29 : 5'd28;
        end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            r = 5'd30;
        end else begin
            r = 5'd31;
        end
        return r;
    endfunction

    // Days from the start of the era to March 1 of year yoe of the era.
    function automatic logic [17:0] yoe_days(input logic [8:0] yoe);
        logic [1:0] cent;
        cent = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
        return 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(cent);
    endfunction

endpackage

### rtl/core/amed_split.sv
// ----------------------------------------------------------------------------
// Date split pipeline
// Breaks a day count into year, month and day and forms the biased month index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amed_split import amed_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] base_date,
    input  logic signed [31:0] month_offset,
    output logic               out_valid,
    input  logic               out_ready,
    output split_t             out_data
);

    localparam int NSTG = 10;
    // Shifts the day count so the era quotient is never negative.
    localparam logic [33:0] Z_BIAS    = 34'd2148345368;
    localparam logic [15:0] ERA_BIAS  = 16'd14700;
    localparam logic [29:0] RECIP_ERA = 30'd963315388;
    localparam logic [11:0] RECIP_153 = 12'd3427;
    localparam logic [17:0] CENT_DAYS = 18'd36524;
    localparam logic [33:0] IDX_BIAS  = 34'd2400000000;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;

    logic [1:0]         flg_reg [NSTG];
    logic signed [31:0] offs_reg [NSTG-1];

    logic [32:0]        zb1_reg, zb1_next, zb2_reg;
    logic [14:0]        qe2_reg, qe2_next, qe3_reg;
    logic [18:0]        rem3_reg, rem3_next;
    logic [17:0]        doe4_reg, doe4_next, doe5_reg, doe6_reg;
    logic signed [15:0] era4_reg, era4_next, era5_reg, era6_reg;
    logic [17:0]        t5_reg, t5_next;
    logic [8:0]         yoe6_reg, yoe6_next, yoe7_reg, yoe8_reg;
    logic [8:0]         doy7_reg, doy7_next, doy8_reg;
    logic signed [23:0] ybase7_reg, ybase7_next, ybase8_reg;
    logic [3:0]         mp8_reg, mp8_next;
    logic [4:0]         d9_reg, d9_next, d10_reg;
    logic [3:0]         m9_reg, m9_next;
    logic signed [23:0] y9_reg, y9_next;
    logic [8:0]         yl9_reg, yl9_next;
    logic               at_end10_reg, at_end10_next;
    logic [32:0]        idx10_reg, idx10_next;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next = {vld_reg[NSTG-2:0], in_valid};
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    always_comb begin
        logic [33:0] zsum;
        logic [55:0] p2;
        logic [33:0] r3;
        logic [14:0] q4;
        logic [36:0] p5;
        logic [7:0]  a5;
        logic [2:0]  b5;
        logic [36:0] p6;
        logic [10:0] n8;
        logic [22:0] p8;
        logic        lt3;
        logic [33:0] s10;

        zsum    = 34'(base_date) + Z_BIAS;
        zb1_next = zsum[32:0];

        p2       = 56'(zb1_reg[32:7]) * 56'(RECIP_ERA);
        qe2_next = p2[54:40];

        r3        = {1'b0, zb2_reg} - 34'(qe2_reg) * 34'(ERA_DAYS);
        rem3_next = r3[18:0];

        if (rem3_reg >= 19'(ERA_DAYS)) begin
            doe4_next = 18'(rem3_reg - 19'(ERA_DAYS));
            q4        = qe3_reg + 15'd1;
        end else begin
            doe4_next = rem3_reg[17:0];
            q4        = qe3_reg;
        end
        era4_next = 16'({1'b0, q4} - ERA_BIAS);

        p5 = 37'(doe4_reg) * 37'(RECIP_365);
        a5 = p5[36:29];
        b5 = 3'(doe4_reg >= CENT_DAYS) + 3'(doe4_reg >= 18'(2 * CENT_DAYS))
           + 3'(doe4_reg >= 18'(3 * CENT_DAYS)) + 3'(doe4_reg >= 18'(4 * CENT_DAYS));
        t5_next = doe4_reg - 18'(a5) + 18'(b5) - 18'(doe4_reg == 18'(4 * CENT_DAYS));

        p6        = 37'(t5_reg) * 37'(RECIP_365);
        yoe6_next = p6[35:27];

        doy7_next   = 9'(doe6_reg - yoe_days(yoe6_reg));
        ybase7_next = 24'(era6_reg) * 24'sd400 + 24'(yoe6_reg);

        n8       = 11'(doy7_reg) * 11'd5 + 11'd2;
        p8       = 23'(n8) * 23'(RECIP_153);
        mp8_next = p8[22:19];

        lt3      = (mp8_reg >= 4'd10);
        d9_next  = 5'(doy8_reg - month_start(mp8_reg) + 9'd1);
        m9_next  = lt3 ? mp8_reg - 4'd9 : mp8_reg + 4'd3;
        y9_next  = ybase8_reg + 24'(lt3);
        yl9_next = yoe8_reg + 9'(lt3);

        at_end10_next = (d9_reg == month_len(m9_reg, is_leap400(yl9_reg)));
        s10 = (34'(y9_reg) << 3) + (34'(y9_reg) << 2) + 34'(m9_reg) - 34'd1
            + 34'(offs_reg[NSTG-2]) + IDX_BIAS;
        idx10_next = s10[32:0];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            flg_reg[0]  <= {(base_date == $signed(POS_INF)) || (base_date == $signed(NEG_INF)),
                            base_date[31]};
            offs_reg[0] <= month_offset;
            zb1_reg     <= zb1_next;
        end
        for (int i = 1; i < NSTG; i++) begin
            if (en[i]) begin
                flg_reg[i] <= flg_reg[i-1];
            end
        end
        for (int i = 1; i < NSTG - 1; i++) begin
            if (en[i]) begin
                offs_reg[i] <= offs_reg[i-1];
            end
        end
        if (en[1]) begin
            zb2_reg <= zb1_reg;
            qe2_reg <= qe2_next;
        end
        if (en[2]) begin
            rem3_reg <= rem3_next;
            qe3_reg  <= qe2_reg;
        end
        if (en[3]) begin
            doe4_reg <= doe4_next;
            era4_reg <= era4_next;
        end
        if (en[4]) begin
            doe5_reg <= doe4_reg;
            era5_reg <= era4_reg;
            t5_reg   <= t5_next;
        end
        if (en[5]) begin
            doe6_reg <= doe5_reg;
            era6_reg <= era5_reg;
            yoe6_reg <= yoe6_next;
        end
        if (en[6]) begin
            doy7_reg   <= doy7_next;
            yoe7_reg   <= yoe6_reg;
            ybase7_reg <= ybase7_next;
        end
        if (en[7]) begin
            doy8_reg   <= doy7_reg;
            yoe8_reg   <= yoe7_reg;
            ybase8_reg <= ybase7_reg;
            mp8_reg    <= mp8_next;
        end
        if (en[8]) begin
            d9_reg  <= d9_next;
            m9_reg  <= m9_next;
            y9_reg  <= y9_next;
            yl9_reg <= yl9_next;
        end
        if (en[9]) begin
            at_end10_reg <= at_end10_next;
            d10_reg      <= d9_reg;
            idx10_reg    <= idx10_next;
        end
    end

    always_comb begin
        out_data.inf     = flg_reg[NSTG-1][1];
        out_data.inf_neg = flg_reg[NSTG-1][0];
        out_data.at_end  = at_end10_reg;
        out_data.day     = d10_reg;
        out_data.midx    = idx10_reg;
    end

endmodule

### rtl/core/amed_shift.sv
// ----------------------------------------------------------------------------
// Month shift pipeline
// Splits the month index into target year and month and clamps the day.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amed_shift import amed_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  split_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output shift_t out_data
);

    localparam int NSTG = 5;
    localparam logic [31:0] RECIP_3   = 32'd2863311531;
    localparam logic [25:0] RECIP_25  = 26'd42949673;
    // Moves the March-based year so that the 400-year quotient is never negative.
    localparam logic [29:0] Y400_BIAS = 30'd9715200;
    localparam logic [20:0] ERA_BIAS  = 21'd524288;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;

    logic [1:0] flg_reg [NSTG];
    logic       end_reg [NSTG-1];
    logic [4:0] day_reg [NSTG-1];

    logic [29:0]        q1_reg, q1_next;
    logic [3:0]         ilo1_reg;
    logic [3:0]         nm2_reg, nm2_next, nm3_reg, nm4_reg;
    logic [29:0]        yb2_reg, yb2_next;
    logic [19:0]        q3_reg, q3_next;
    logic [8:0]         yblo3_reg;
    logic [8:0]         yoe4_reg, yoe4_next, yoe5_reg;
    logic signed [20:0] era4_reg, era4_next, era5_reg;
    logic [4:0]         nd5_reg, nd5_next;
    logic [3:0]         mp5_reg, mp5_next;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next = {vld_reg[NSTG-2:0], in_valid};
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    always_comb begin
        logic [62:0] p1;
        logic [3:0]  nm0;
        logic        lt3;
        logic [50:0] p3;
        logic [4:0]  tlen;

        p1      = 63'(in_data.midx[32:2]) * 63'(RECIP_3);
        q1_next = p1[62:33];

        nm0      = ilo1_reg - 4'(q1_reg * 30'd12);
        lt3      = (nm0 < 4'd2);
        nm2_next = nm0 + 4'd1;
        yb2_next = q1_reg + Y400_BIAS - 30'(lt3);

        p3      = 51'(yb2_reg[28:4]) * 51'(RECIP_25);
        q3_next = p3[49:30];

        yoe4_next = yblo3_reg - 9'(q3_reg * 20'd400);
        era4_next = 21'({1'b0, q3_reg} - ERA_BIAS);

        tlen = month_len(nm4_reg, is_leap400(yoe4_reg + 9'd1));
        if (end_reg[3] || (day_reg[3] > tlen)) begin
            nd5_next = tlen;
        end else begin
            nd5_next = day_reg[3];
        end
        mp5_next = (nm4_reg >= 4'd3) ? nm4_reg - 4'd3 : nm4_reg + 4'd9;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            flg_reg[0] <= {in_data.inf, in_data.inf_neg};
            end_reg[0] <= in_data.at_end;
            day_reg[0] <= in_data.day;
            q1_reg     <= q1_next;
            ilo1_reg   <= in_data.midx[3:0];
        end
        for (int i = 1; i < NSTG; i++) begin
            if (en[i]) begin
                flg_reg[i] <= flg_reg[i-1];
            end
        end
        for (int i = 1; i < NSTG - 1; i++) begin
            if (en[i]) begin
                end_reg[i] <= end_reg[i-1];
                day_reg[i] <= day_reg[i-1];
            end
        end
        if (en[1]) begin
            nm2_reg <= nm2_next;
            yb2_reg <= yb2_next;
        end
        if (en[2]) begin
            nm3_reg   <= nm2_reg;
            q3_reg    <= q3_next;
            yblo3_reg <= yb2_reg[8:0];
        end
        if (en[3]) begin
            nm4_reg  <= nm3_reg;
            yoe4_reg <= yoe4_next;
            era4_reg <= era4_next;
        end
        if (en[4]) begin
            yoe5_reg <= yoe4_reg;
            era5_reg <= era4_reg;
            nd5_reg  <= nd5_next;
            mp5_reg  <= mp5_next;
        end
    end

    always_comb begin
        out_data.inf     = flg_reg[NSTG-1][1];
        out_data.inf_neg = flg_reg[NSTG-1][0];
        out_data.yoe     = yoe5_reg;
        out_data.era     = era5_reg;
        out_data.day     = nd5_reg;
        out_data.mp      = mp5_reg;
    end

endmodule

### rtl/core/amed_join.sv
// ----------------------------------------------------------------------------
// Date join pipeline
// Converts the target date back to a day count and checks its range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amed_join import amed_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  shift_t      in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_date,
    output logic        range_error
);

    localparam int NSTG = 3;
    localparam logic signed [38:0] ERA_DAYS_W  = 39'sd146097;
    localparam logic signed [38:0] EPOCH_SHIFT = 39'sd719468;
    localparam logic signed [38:0] RES_LO      = -39'sd2147483647;
    localparam logic signed [38:0] RES_HI      = 39'sd2147483647;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;

    logic [1:0] flg_reg [NSTG-1];

    logic [17:0]        doe1_reg, doe1_next;
    logic signed [38:0] eprod1_reg, eprod1_next;
    logic signed [38:0] res2_reg, res2_next;
    logic [31:0]        date3_reg, date3_next;
    logic               err3_reg, err3_next;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next = {vld_reg[NSTG-2:0], in_valid};
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    always_comb begin
        doe1_next = yoe_days(in_data.yoe) + 18'(month_start(in_data.mp))
                  + 18'(in_data.day) - 18'd1;
        eprod1_next = 39'($signed(in_data.era)) * ERA_DAYS_W;

        res2_next = eprod1_reg + $signed({21'b0, doe1_reg}) - EPOCH_SHIFT;

        if (flg_reg[1][1]) begin
            date3_next = flg_reg[1][0] ? NEG_INF : POS_INF;
            err3_next  = 1'b0;
        end else if ((res2_reg <= RES_LO) || (res2_reg >= RES_HI)) begin
            date3_next = 32'd0;
            err3_next  = 1'b1;
        end else begin
            date3_next = res2_reg[31:0];
            err3_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            flg_reg[0] <= {in_data.inf, in_data.inf_neg};
            doe1_reg   <= doe1_next;
            eprod1_reg <= eprod1_next;
        end
        if (en[1]) begin
            flg_reg[1] <= flg_reg[0];
            res2_reg   <= res2_next;
        end
        if (en[2]) begin
            date3_reg <= date3_next;
            err3_reg  <= err3_next;
        end
    end

    assign result_date = date3_reg;
    assign range_error = err3_reg;

endmodule

### rtl/core/add_months_end_of_month_date_core.sv
// Throughput: one transfer per cycle while the output is not stalled.
// Split, shift and join form 18 register stages, each with its own valid bit.
// A stalled output holds the last stage while earlier empty stages keep filling.
// Reset: aresetn is synchronous and active low; it clears every stage valid bit.
// ----------------------------------------------------------------------------
// Add-months date core with the end-of-month rule
// Shifts a day count by a signed number of months in the Gregorian calendar.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "add_months_end_of_month_date_core_macros.svh"

module add_months_end_of_month_date_core import amed_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] base_date, [63:32] month_offset
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_date
    output logic [0:0]  m_tuser    // [0] range_error
);

    logic   split_valid;
    logic   split_ready;
    split_t split_data;
    logic   shift_valid;
    logic   shift_ready;
    shift_t shift_data;
    logic   range_error;

    amed_split u_split (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .base_date    ($signed(s_tdata[31:0])),
        .month_offset ($signed(s_tdata[63:32])),
        .out_valid    (split_valid),
        .out_ready    (split_ready),
        .out_data     (split_data)
    );

    amed_shift u_shift (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (split_valid),
        .in_ready  (split_ready),
        .in_data   (split_data),
        .out_valid (shift_valid),
        .out_ready (shift_ready),
        .out_data  (shift_data)
    );

    amed_join u_join (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (shift_valid),
        .in_ready    (shift_ready),
        .in_data     (shift_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .result_date (m_tdata),
        .range_error (range_error)
    );

    assign m_tuser = range_error;

    `AMED_ASSERT_IMP(a_err_date_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 32'd0, "Range error transfer carries a nonzero date")
    `AMED_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready, "Input stalled while the output stage is empty")
    `AMED_ASSERT_NEVER(a_no_min_code, aclk, aresetn, m_tvalid && (m_tdata == 32'h8000_0000), "Result holds the unrepresentable minimum code")

endmodule
